@@ rtl/mft_pkg.sv @@
// ----------------------------------------------------------------------------
// mft_pkg: shared types and codes for the sorted multiset floor-take block
// Opcodes, result status codes and the control word broadcast to every cell.
// ----------------------------------------------------------------------------
package mft_pkg;

	localparam int VAL_W = 32;

	// opcodes
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_TAKE   = 1'b1;

	// result status codes
	localparam logic [1:0] ST_INSERTED = 2'd0;
	localparam logic [1:0] ST_TAKEN    = 2'd1;
	localparam logic [1:0] ST_NONE     = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	// control broadcast to the cell row
	typedef struct packed {
		logic             cmp_en;     // latch compare flags against cmp_value
		logic [VAL_W-1:0] cmp_value;
		logic             ins_en;     // open a slot and shift the upper part up
		logic             take_en;    // close the slot and shift the upper part down
		logic [VAL_W-1:0] ins_value;
	} mft_ctl_t;

endpackage

@@ rtl/mft_cell.sv @@
// ----------------------------------------------------------------------------
// mft_cell: one slot of the sorted row
// Holds one value and its compare flag; shifts toward either neighbor.
// ----------------------------------------------------------------------------
module mft_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mft_pkg::mft_ctl_t           ctl,
	input  logic                        occupied,
	input  logic                        left_le,
	input  logic [mft_pkg::VAL_W-1:0]   left_value,
	input  logic                        right_le,
	input  logic [mft_pkg::VAL_W-1:0]   right_value,
	output logic                        le,
	output logic                        sel,
	output logic [mft_pkg::VAL_W-1:0]   value
);

	logic                      le_q;
	logic [mft_pkg::VAL_W-1:0] value_q;

	// hold the "stored value not above query" flag for the current item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			le_q <= 1'b0;
		end else if (ctl.cmp_en) begin
			le_q <= occupied && (value_q <= ctl.cmp_value);
		end
	end

	// insert: slots above the split take the new value or the left neighbor
	// take: slots from the removed one upward take the right neighbor
	always_ff @(posedge clk) begin
		if (ctl.ins_en && !le_q) begin
			value_q <= left_le ? ctl.ins_value : left_value;
		end else if (ctl.take_en && !right_le) begin
			value_q <= right_value;
		end
	end

	// last slot whose value is not above the query
	assign sel   = le_q && !right_le;
	assign le    = le_q;
	assign value = value_q;

endmodule

@@ rtl/mft_group.sv @@
// ----------------------------------------------------------------------------
// mft_group: first level of the selected-value reduction
// Registers the value of the selected lane within one group of cells.
// ----------------------------------------------------------------------------
module mft_group #(
	parameter int LANES = 32
) (
	input  logic                                   clk,
	input  logic                                   en,
	input  logic [LANES-1:0]                       sel,
	input  logic [LANES-1:0][mft_pkg::VAL_W-1:0]   values,
	output logic [mft_pkg::VAL_W-1:0]              hit_value
);

	logic [mft_pkg::VAL_W-1:0] hit_d;
	logic [mft_pkg::VAL_W-1:0] hit_q;

	// at most one lane is selected, so an OR of masked lanes picks it
	always_comb begin
		hit_d = '0;
		for (int i = 0; i < LANES; i++) begin
			hit_d = hit_d | (values[i] & {mft_pkg::VAL_W{sel[i]}});
		end
	end

	// capture before the row shifts, hold while the result waits
	always_ff @(posedge clk) begin
		if (en) begin
			hit_q <= hit_d;
		end
	end

	assign hit_value = hit_q;

endmodule

@@ rtl/multiset_floor_take.sv @@
// ----------------------------------------------------------------------------
// multiset_floor_take: sorted multiset with insert and floor-take
// Row of compare-and-shift cells holding up to CAPACITY values in order.
// ----------------------------------------------------------------------------
// For each item the cells compare the query on the transfer edge, then in the
// update state they shift while the first OR level (groups of 32 cells)
// registers the removed value of a take, and in the final state the second
// OR level over the groups loads the output register once it is free. The
// input is ready again only when the sequencer is back in idle, so a new item
// is not accepted until the previous one has left the final state.
// One item is in work at a time; a new item is taken while an earlier result
// still waits in the output register, and its own result is then held back
// until that register drains. Status 0 means inserted, 1 a value was taken,
// 2 nothing not above the query, 3 store full.
// Cells above the fill count hold no meaningful data and need no clearing.
// ----------------------------------------------------------------------------
module multiset_floor_take #(
	parameter int CAPACITY = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        opcode,
	input  logic [31:0] item_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [31:0] taken_value
);

	localparam int CW     = $clog2(CAPACITY + 1);
	localparam int GROUP  = 32;
	localparam int NGROUP = (CAPACITY + GROUP - 1) / GROUP;
	localparam int NPAD   = NGROUP * GROUP;
	localparam int VW     = mft_pkg::VAL_W;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_UPD  = 3'b010,
		S_FIN  = 3'b100
	} state_t;

	state_t            state_q;
	logic              op_q;
	logic [VW-1:0]     query_q;
	logic [CW-1:0]     count_q;
	logic [1:0]        status_q;
	logic              out_valid_q;
	logic [1:0]        out_status_q;
	logic [VW-1:0]     out_value_q;

	logic              in_xfer;
	logic              do_ins;
	logic              do_take;
	logic              full;
	logic              upd;
	mft_pkg::mft_ctl_t ctl;

	logic [CAPACITY-1:0]          cell_le;
	logic [CAPACITY-1:0]          cell_sel;
	logic [CAPACITY-1:0][VW-1:0]  cell_value;
	logic [NPAD-1:0]              pad_sel;
	logic [NPAD-1:0][VW-1:0]      pad_value;
	logic [NGROUP-1:0][VW-1:0]    group_value;
	logic [VW-1:0]                hit_value;

	assign in_xfer = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign upd     = (state_q == S_UPD);
	assign full    = (count_q == CW'(CAPACITY));
	assign do_ins  = upd && (op_q == mft_pkg::OP_INSERT) && !full;
	assign do_take = upd && (op_q == mft_pkg::OP_TAKE) && cell_le[0];

	// broadcast control to the row
	always_comb begin
		ctl.cmp_en    = in_xfer;
		ctl.cmp_value = item_value;
		ctl.ins_en    = do_ins;
		ctl.take_en   = do_take;
		ctl.ins_value = query_q;
	end

	// cell row
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic          left_le;
		logic [VW-1:0] left_value;
		logic          right_le;
		logic [VW-1:0] right_value;

		if (i == 0) begin : g_first
			assign left_le    = 1'b1;
			assign left_value = query_q;
		end else begin : g_mid_l
			assign left_le    = cell_le[i-1];
			assign left_value = cell_value[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_le    = 1'b0;
			assign right_value = cell_value[i];
		end else begin : g_mid_r
			assign right_le    = cell_le[i+1];
			assign right_value = cell_value[i+1];
		end

		mft_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.occupied    (CW'(i) < count_q),
			.left_le     (left_le),
			.left_value  (left_value),
			.right_le    (right_le),
			.right_value (right_value),
			.le          (cell_le[i]),
			.sel         (cell_sel[i]),
			.value       (cell_value[i])
		);
	end

	// pad the row to whole groups
	for (genvar j = 0; j < NPAD; j++) begin : g_pad
		if (j < CAPACITY) begin : g_real
			assign pad_sel[j]   = cell_sel[j];
			assign pad_value[j] = cell_value[j];
		end else begin : g_zero
			assign pad_sel[j]   = 1'b0;
			assign pad_value[j] = '0;
		end
	end

	// first reduction level, registered per group in the update cycle
	for (genvar g = 0; g < NGROUP; g++) begin : g_group
		mft_group #(
			.LANES (GROUP)
		) u_group (
			.clk       (clk),
			.en        (upd),
			.sel       (pad_sel[g*GROUP +: GROUP]),
			.values    (pad_value[g*GROUP +: GROUP]),
			.hit_value (group_value[g])
		);
	end

	// second reduction level over the groups
	always_comb begin
		hit_value = '0;
		for (int g = 0; g < NGROUP; g++) begin
			hit_value = hit_value | group_value[g];
		end
	end

	// hold the item fields for the update cycle
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q    <= opcode;
			query_q <= item_value;
		end
	end

	// sequencer, fill count and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			status_q     <= mft_pkg::ST_INSERTED;
			out_valid_q  <= 1'b0;
			out_status_q <= mft_pkg::ST_INSERTED;
			out_value_q  <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					if (op_q == mft_pkg::OP_INSERT) begin
						status_q <= full ? mft_pkg::ST_FULL : mft_pkg::ST_INSERTED;
					end else begin
						status_q <= cell_le[0] ? mft_pkg::ST_TAKEN : mft_pkg::ST_NONE;
					end
					if (do_ins) begin
						count_q <= count_q + CW'(1);
					end else if (do_take) begin
						count_q <= count_q - CW'(1);
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					// wait for the output register to drain
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= status_q;
						out_value_q  <= (status_q == mft_pkg::ST_TAKEN) ? hit_value : '0;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign taken_value = out_value_q;

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: randomized check of the sorted multiset floor-take block
// Runs a directed opening, then mixed traffic, a fill past capacity, work at a
// full store and a drain. A scoreboard mirrors the stored values and checks
// status and taken value of each result against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

	localparam int CAPACITY    = 1024;
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_AT     = 400;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE      = 10;

	typedef struct {
		logic        op;
		logic [31:0] val;
	} request_t;

	typedef struct {
		logic [1:0]  status;
		logic [31:0] value;
	} result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        opcode = mft_pkg::OP_INSERT;
	logic [31:0] item_value = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  status;
	logic [31:0] taken_value;

	request_t    queued_requests[$];
	result_t     pending_results[$];
	logic [31:0] held_values[$];
	int          send_gap;
	int          recv_gap;
	int          sent_count;
	int          results_seen;
	int          idle_cycles;
	int          error_count;

	multiset_floor_take #(.CAPACITY(CAPACITY)) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.item_value (item_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.taken_value(taken_value)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// mirror one item on the held multiset and return its result
	function automatic result_t predict_floor_take(input logic op, input logic [31:0] v);
		result_t r;
		int      p;
		r.status = mft_pkg::ST_INSERTED;
		r.value  = '0;
		p = 0;
		while (p < held_values.size() && held_values[p] <= v)
			p++;
		if (op == mft_pkg::OP_INSERT) begin
			if (held_values.size() >= CAPACITY)
				r.status = mft_pkg::ST_FULL;
			else
				held_values.insert(p, v);
		end else if (p == 0) begin
			r.status = mft_pkg::ST_NONE;
		end else begin
			r.status = mft_pkg::ST_TAKEN;
			r.value  = held_values[p - 1];
			held_values.delete(p - 1);
		end
		return r;
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// favor small values so duplicates pile up, with extremes and full range
	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom_range(0, 15);
			4: begin
				case ($urandom_range(0, 3))
					0: return 32'h0000_0000;
					1: return 32'hFFFF_FFFF;
					2: return 32'h8000_0000;
					default: return 32'h7FFF_FFFF;
				endcase
			end
			default: return $urandom();
		endcase
	endfunction

	task automatic queue_item(input logic op, input logic [31:0] v);
		request_t q;
		q.op  = op;
		q.val = v;
		queued_requests.insert(queued_requests.size(), q);
	endtask

	task automatic queue_random(input int count, input int take_pct);
		for (int i = 0; i < count; i++)
			queue_item(($urandom_range(0, 99) < take_pct) ? mft_pkg::OP_TAKE :
				mft_pkg::OP_INSERT, pick_value());
	endtask

	// drive requests; predict each one on its transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			opcode     <= mft_pkg::OP_INSERT;
			item_value <= '0;
			send_gap   <= 0;
			sent_count <= 0;
		end else begin
			if (in_valid && in_ready) begin
				pending_results.insert(pending_results.size(),
					predict_floor_take(opcode, item_value));
				sent_count <= sent_count + 1;
			end
			if (!in_valid || in_ready) begin
				if (send_gap != 0) begin
					in_valid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (queued_requests.size() != 0) begin
					in_valid   <= 1'b1;
					opcode     <= queued_requests[0].op;
					item_value <= queued_requests[0].val;
					void'(queued_requests.pop_front());
					// keep some stretches free of idling
					send_gap   <= (sent_count % 400 >= 300) ? 0 : pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// accept results, compare against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready    <= 1'b0;
			recv_gap     <= 0;
			results_seen <= 0;
			error_count  <= 0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen <= results_seen + 1;
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result status=%0d taken_value=%h",
						$time, status, taken_value);
					error_count <= error_count + 1;
				end else begin
					if (status !== pending_results[0].status ||
					    taken_value !== pending_results[0].value) begin
						if (status !== pending_results[0].status)
							$display("%0t: status expected %0d actual %0d",
								$time, pending_results[0].status, status);
						if (taken_value !== pending_results[0].value)
							$display("%0t: taken_value expected %h actual %h",
								$time, pending_results[0].value, taken_value);
						error_count <= error_count + 1;
					end
					void'(pending_results.pop_front());
				end
			end
			if (recv_gap != 0) begin
				out_ready <= 1'b0;
				recv_gap  <= recv_gap - 1;
			end else if (out_valid && out_ready) begin
				// hold off once for a long stretch so the block backs up
				if (results_seen + 1 == HOLD_AT) begin
					out_ready <= 1'b0;
					recv_gap  <= HOLD_CYCLES;
				end else if (results_seen % 500 >= 350) begin
					out_ready <= 1'b1;
				end else begin
					recv_gap  <= pick_gap();
					out_ready <= 1'b1;
				end
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// count cycles with no transfer on either side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			idle_cycles <= 0;
		else if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		// directed: empty store, extremes, duplicates, exact and between queries
		queue_item(mft_pkg::OP_TAKE,   32'hFFFF_FFFF);
		queue_item(mft_pkg::OP_TAKE,   32'h0000_0000);
		queue_item(mft_pkg::OP_INSERT, 32'h0000_0000);
		queue_item(mft_pkg::OP_INSERT, 32'hFFFF_FFFF);
		queue_item(mft_pkg::OP_INSERT, 32'd5);
		queue_item(mft_pkg::OP_INSERT, 32'd5);
		queue_item(mft_pkg::OP_INSERT, 32'd5);
		queue_item(mft_pkg::OP_INSERT, 32'd1000);
		queue_item(mft_pkg::OP_TAKE,   32'd4);
		queue_item(mft_pkg::OP_TAKE,   32'd4);
		queue_item(mft_pkg::OP_TAKE,   32'd5);
		queue_item(mft_pkg::OP_TAKE,   32'd999);
		queue_item(mft_pkg::OP_TAKE,   32'hFFFF_FFFE);
		queue_item(mft_pkg::OP_TAKE,   32'hFFFF_FFFF);
		queue_item(mft_pkg::OP_TAKE,   32'hFFFF_FFFF);
		queue_item(mft_pkg::OP_TAKE,   32'hFFFF_FFFF);
		queue_item(mft_pkg::OP_INSERT, 32'h8000_0000);
		queue_item(mft_pkg::OP_INSERT, 32'h7FFF_FFFF);
		queue_item(mft_pkg::OP_TAKE,   32'h7FFF_FFFF);
		queue_item(mft_pkg::OP_TAKE,   32'h0000_0000);
		queue_item(mft_pkg::OP_TAKE,   32'h8000_0000);
		// mixed traffic at low fill
		queue_random(300, 45);
		// fill past capacity, then work at a full store, then drain
		queue_random(1040, 0);
		queue_random(60, 40);
		queue_random(220, 85);

		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while ((queued_requests.size() != 0 || in_valid || pending_results.size() != 0) &&
		       idle_cycles < STALL_LIMIT)
			@(posedge clk);

		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: timeout, no transfer for %0d cycles", $time, idle_cycles);
			$display("FAILED: results differ");
		end else begin
			repeat (SETTLE) @(posedge clk);
			if (error_count == 0)
				$display("PASSED: all results match");
			else
				$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
